FILE: src/dape_pkg.sv
// Shared types and constants for the depth annulus point extractor.
`timescale 1ns / 1ps
`default_nettype none
package dape_pkg;

   // Restoring divider: one quotient bit per stage, quotient saturates at 21 bits
   localparam int DIV_STEPS = 21;
   // Stages of the divider after the capture stage: dx, product, magnitude, init, steps
   localparam int DIV_LAT   = 4 + DIV_STEPS;
   // Stages of the annulus test after the capture stage
   localparam int MASK_LAT  = 6;
   // Delay that lines the mask decision up with the divider result
   localparam int ALIGN_LAT = DIV_LAT - MASK_LAT;

   localparam logic [15:0] MIN_HALF = 16'd32;
   localparam logic [20:0] SAT_POS  = 21'h0FFFFF;
   localparam logic [20:0] SAT_NEG  = 21'h100000;

   // Configuration register indexes
   typedef enum logic [3:0] {
      REG_CENTER_U    = 4'd0,
      REG_CENTER_V    = 4'd1,
      REG_HALF_WIDTH  = 4'd2,
      REG_HALF_HEIGHT = 4'd3,
      REG_FOCAL_X     = 4'd4,
      REG_FOCAL_Y     = 4'd5,
      REG_PRINCIPAL_U = 4'd6,
      REG_PRINCIPAL_V = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] center_u;
      logic [15:0] center_v;
      logic [15:0] half_width;
      logic [15:0] half_height;
      logic [15:0] focal_x;
      logic [15:0] focal_y;
      logic [15:0] principal_u;
      logic [15:0] principal_v;
   } cfg_type;

endpackage
`default_nettype wire

FILE: src/dape_mask.sv
// Elliptic annulus membership test, pipelined over six stages.
`timescale 1ns / 1ps
`default_nettype none
module dape_mask #(
   parameter int MAX_COLS       = 4096,
   parameter int MAX_ROWS       = 4096,
   parameter int INNER_RATIO_Q8 = 128
) (
   input  wire logic             clock,
   input  wire logic             adv,
   input  wire dape_pkg::cfg_type cfg,
   input  wire logic [11:0]      pixel_u,
   input  wire logic [11:0]      pixel_v,
   input  wire logic [15:0]      depth_mm,
   output logic                  keep
);
   import dape_pkg::*;

   localparam logic [15:0] R2 = 16'(INNER_RATIO_Q8 * INNER_RATIO_Q8);

   logic signed [17:0] du_s, dv_s;
   logic [17:0]  du_a, dv_a;
   logic         rej_in;

   logic [15:0]  du_ff, dv_ff;
   logic         rej2_ff;
   logic [31:0]  du2_ff, dv2_ff, hw2_ff, hh2_ff;
   logic         rej3_ff;
   logic [63:0]  a_ff, b_ff, p4_ff;
   logic         rej4_ff;
   logic [64:0]  s5_ff;
   logic [63:0]  p5_ff;
   logic [47:0]  rp_lo_ff, rp_hi_ff;
   logic         rej5_ff;
   logic [64:0]  s6_ff;
   logic [79:0]  rp_ff;
   logic         outer_ff, rej6_ff;
   logic         keep_ff;

   // offsets from the centre in 1/16 pixel
   always_comb begin
      du_s   = $signed({2'b00, pixel_u, 4'b0000}) - $signed({2'b00, cfg.center_u});
      dv_s   = $signed({2'b00, pixel_v, 4'b0000}) - $signed({2'b00, cfg.center_v});
      du_a   = du_s[17] ? 18'(-du_s) : du_s;
      dv_a   = dv_s[17] ? 18'(-dv_s) : dv_s;
      rej_in = (cfg.half_width < MIN_HALF) || (cfg.half_height < MIN_HALF) ||
               (depth_mm == 16'd0) ||
               ({1'b0, pixel_u} >= 13'(MAX_COLS)) || ({1'b0, pixel_v} >= 13'(MAX_ROWS));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // offsets and early rejects
         du_ff   <= du_a[15:0];
         dv_ff   <= dv_a[15:0];
         rej2_ff <= rej_in;
         // squares and bounding box check
         du2_ff  <= du_ff * du_ff;
         dv2_ff  <= dv_ff * dv_ff;
         hw2_ff  <= cfg.half_width * cfg.half_width;
         hh2_ff  <= cfg.half_height * cfg.half_height;
         rej3_ff <= rej2_ff || (du_ff > cfg.half_width) || (dv_ff > cfg.half_height);
         // cross products
         a_ff    <= du2_ff * hh2_ff;
         b_ff    <= dv2_ff * hw2_ff;
         p4_ff   <= hw2_ff * hh2_ff;
         rej4_ff <= rej3_ff;
         // sum and inner bound partial products
         s5_ff    <= {1'b0, a_ff} + {1'b0, b_ff};
         p5_ff    <= p4_ff;
         rp_lo_ff <= R2 * p4_ff[31:0];
         rp_hi_ff <= R2 * p4_ff[63:32];
         rej5_ff  <= rej4_ff;
         // outer test and inner bound sum
         outer_ff <= s5_ff <= {1'b0, p5_ff};
         rp_ff    <= {rp_hi_ff, 32'h0} + {32'h0, rp_lo_ff};
         s6_ff    <= s5_ff;
         rej6_ff  <= rej5_ff;
         // strictly outside the inner ellipse: 65536 * s > r^2 * p
         keep_ff  <= !rej6_ff && outer_ff && ({s6_ff, 16'h0} > {1'b0, rp_ff});
      end
   end

   assign keep = keep_ff;

endmodule
`default_nettype wire

FILE: src/dape_div.sv
// One axis of the back-projection: (16*coord - principal) * depth / focal, rounded, saturated.
`timescale 1ns / 1ps
`default_nettype none
module dape_div (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [11:0] coord,
   input  wire logic [15:0] principal,
   input  wire logic [15:0] focal,
   input  wire logic [15:0] depth_mm,
   output logic [20:0]      value,
   output logic             clip
);
   import dape_pkg::*;

   logic [15:0]        den;
   logic signed [17:0] dx_ff;
   logic [15:0]        z_ff;
   logic signed [34:0] n_ff;
   logic [34:0]        n_abs;
   logic               neg_a_ff;
   logic [32:0]        mag_ff;

   logic [15:0] rem_ff [0:DIV_STEPS-1];
   logic [20:0] wk_ff  [0:DIV_STEPS];
   logic        ovf_ff [0:DIV_STEPS];
   logic        neg_ff [0:DIV_STEPS];

   logic [16:0] trial  [1:DIV_STEPS];
   logic [16:0] diff   [1:DIV_STEPS];
   logic        ge     [1:DIV_STEPS];

   logic [20:0] q;
   logic        neg_l;

   // a zero focal length acts as one
   assign den   = (focal == 16'd0) ? 16'd1 : focal;
   assign n_abs = n_ff[34] ? 35'(-n_ff) : n_ff;

   // one restoring step per stage
   always_comb begin
      for (int k = 1; k <= DIV_STEPS; k++) begin
         trial[k] = {rem_ff[k-1], wk_ff[k-1][20]};
         diff[k]  = trial[k] - {1'b0, den};
         ge[k]    = trial[k] >= {1'b0, den};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // offset from the principal point
         dx_ff    <= $signed({2'b00, coord, 4'b0000}) - $signed({2'b00, principal});
         z_ff     <= depth_mm;
         // numerator
         n_ff     <= dx_ff * $signed({1'b0, z_ff});
         // magnitude plus half the divisor for round to nearest
         neg_a_ff <= n_ff[34];
         mag_ff   <= {1'b0, n_abs[31:0]} + {18'h0, den[15:1]};
         // high part that must stay below the divisor for a 21-bit quotient
         rem_ff[0] <= {4'h0, mag_ff[32:21]};
         wk_ff[0]  <= mag_ff[20:0];
         ovf_ff[0] <= {4'h0, mag_ff[32:21]} >= den;
         neg_ff[0] <= neg_a_ff;
         // the last step keeps only its quotient bit
         for (int k = 1; k < DIV_STEPS; k++) begin
            rem_ff[k] <= ge[k] ? diff[k][15:0] : trial[k][15:0];
         end
         for (int k = 1; k <= DIV_STEPS; k++) begin
            wk_ff[k]  <= {wk_ff[k-1][19:0], ge[k]};
            ovf_ff[k] <= ovf_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   // sign and saturation
   always_comb begin
      q     = wk_ff[DIV_STEPS];
      neg_l = neg_ff[DIV_STEPS];
      clip  = ovf_ff[DIV_STEPS] || (neg_l ? (q[20] && (q[19:0] != 20'h0)) : q[20]);
      if (clip) value = neg_l ? SAT_NEG : SAT_POS;
      else      value = neg_l ? 21'(-q) : q;
   end

endmodule
`default_nettype wire

FILE: src/depth_annulus_point_extract_core.sv
// Top level: config registers, capture stage, mask and divider pipes, output register.
// An accepted req item passes the capture stage, the mask and divider pipes and the output register to rsp_tvalid.
// Throughput: one item per cycle while the output is not stalled; the depth of the restoring divider sets the latency.
// Items that fail the mask or depth checks leave no rsp item.
// Reset (synchronous, active high) empties the pipe and loads the config defaults.
`timescale 1ns / 1ps
`default_nettype none
module depth_annulus_point_extract_core #(
   parameter int MAX_COLS       = 4096,
   parameter int MAX_ROWS       = 4096,
   parameter int INNER_RATIO_Q8 = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: pixel_u[11:0], pixel_v[23:12], depth_mm[39:24]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // rsp_tdata: point_x_mm[20:0], point_y_mm[41:21], point_z_mm[57:42], zero[63:58]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,
   // rsp_tuser: clipped[0]
   output logic             rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import dape_pkg::*;

   cfg_type     cfg_ff;
   logic        adv;
   logic        vld_ff  [0:DIV_LAT];
   logic [15:0] z_ff    [0:DIV_LAT];
   logic [11:0] pu_ff, pv_ff;
   logic        keep;
   logic        keep_ff [0:ALIGN_LAT-1];
   logic [20:0] x_val, y_val;
   logic        x_clip, y_clip;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   // whole pipe moves when the output register is free or being drained
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '0;
         cfg_ff.focal_x <= 16'd9600;
         cfg_ff.focal_y <= 16'd9600;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_CENTER_U:    cfg_ff.center_u    <= csr_data;
            REG_CENTER_V:    cfg_ff.center_v    <= csr_data;
            REG_HALF_WIDTH:  cfg_ff.half_width  <= csr_data;
            REG_HALF_HEIGHT: cfg_ff.half_height <= csr_data;
            REG_FOCAL_X:     cfg_ff.focal_x     <= csr_data;
            REG_FOCAL_Y:     cfg_ff.focal_y     <= csr_data;
            REG_PRINCIPAL_U: cfg_ff.principal_u <= csr_data;
            REG_PRINCIPAL_V: cfg_ff.principal_v <= csr_data;
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k <= DIV_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // capture stage, depth delay line and mask alignment
   always_ff @(posedge clock) begin
      if (adv) begin
         pu_ff   <= req_tdata[11:0];
         pv_ff   <= req_tdata[23:12];
         z_ff[0] <= req_tdata[39:24];
         for (int k = 1; k <= DIV_LAT; k++) z_ff[k] <= z_ff[k-1];
         keep_ff[0] <= keep;
         for (int k = 1; k < ALIGN_LAT; k++) keep_ff[k] <= keep_ff[k-1];
      end
   end

   dape_mask #(
      .MAX_COLS       (MAX_COLS),
      .MAX_ROWS       (MAX_ROWS),
      .INNER_RATIO_Q8 (INNER_RATIO_Q8)
   ) u_mask (
      .clock    (clock),
      .adv      (adv),
      .cfg      (cfg_ff),
      .pixel_u  (pu_ff),
      .pixel_v  (pv_ff),
      .depth_mm (z_ff[0]),
      .keep     (keep)
   );

   dape_div u_div_x (
      .clock     (clock),
      .adv       (adv),
      .coord     (pu_ff),
      .principal (cfg_ff.principal_u),
      .focal     (cfg_ff.focal_x),
      .depth_mm  (z_ff[0]),
      .value     (x_val),
      .clip      (x_clip)
   );

   dape_div u_div_y (
      .clock     (clock),
      .adv       (adv),
      .coord     (pv_ff),
      .principal (cfg_ff.principal_v),
      .focal     (cfg_ff.focal_y),
      .depth_mm  (z_ff[0]),
      .value     (y_val),
      .clip      (y_clip)
   );

   // output register, drops items that failed the mask
   assign rsp_tvalid_in = vld_ff[DIV_LAT] && keep_ff[ALIGN_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {6'h0, z_ff[DIV_LAT], y_val, x_val};
         rsp_tuser_ff <= x_clip || y_clip;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
`default_nettype wire

FILE: src/dape_checker.sv
// Port-level checks for the point extractor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dape_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // an empty output register never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // every point has a nonzero depth and zero padding
   a_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[57:42] != 16'h0) && (rsp_tdata[63:58] == 6'h0))
      else $error("point with zero depth or dirty padding");

   // a clipped point carries a saturated coordinate
   a_clip_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[20:0] == 21'h0FFFFF) || (rsp_tdata[20:0] == 21'h100000) ||
         (rsp_tdata[41:21] == 21'h0FFFFF) || (rsp_tdata[41:21] == 21'h100000))
      else $error("clip flag without saturated coordinate");

endmodule

bind depth_annulus_point_extract_core dape_checker u_dape_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

FILE: tb/sv/tb_depth_annulus_point_extract_core.sv
// Self-checking testbench for the depth annulus point extractor core.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
   logic [20:0] x;
   logic [20:0] y;
   logic [15:0] z;
   logic        clip;
} point_type;

// Predicts extracted points and checks them in order
class point_scoreboard;
   logic [15:0] cu, cv, hw, hh, fx, fy, pu0, pv0;
   point_type   pending[$];
   int          errors;

   function void reset_regs();
      cu = 0; cv = 0; hw = 0; hh = 0; fx = 16'd9600; fy = 16'd9600; pu0 = 0; pv0 = 0;
   endfunction

   function void write_reg(dape_pkg::reg_index_type idx, logic [15:0] val);
      case (idx)
         dape_pkg::REG_CENTER_U:    cu  = val;
         dape_pkg::REG_CENTER_V:    cv  = val;
         dape_pkg::REG_HALF_WIDTH:  hw  = val;
         dape_pkg::REG_HALF_HEIGHT: hh  = val;
         dape_pkg::REG_FOCAL_X:     fx  = val;
         dape_pkg::REG_FOCAL_Y:     fy  = val;
         dape_pkg::REG_PRINCIPAL_U: pu0 = val;
         dape_pkg::REG_PRINCIPAL_V: pv0 = val;
         default: ;
      endcase
   endfunction

   // rounded, saturated division of one axis
   function logic [20:0] axis(longint n, logic [15:0] f, inout logic clip);
      longint unsigned den, mag;
      longint q;
      den = (f == 0) ? 1 : f;
      mag = ((n < 0 ? -n : n) + den / 2) / den;
      q = n < 0 ? -longint'(mag) : longint'(mag);
      if (q > 1048575) begin q = 1048575; clip = 1; end
      if (q < -1048576) begin q = -1048576; clip = 1; end
      return q[20:0];
   endfunction

   function void note_pixel(logic [11:0] u, logic [11:0] v, logic [15:0] d);
      longint unsigned du, dv, hw2, hh2, a, b, p, s, r2, lim;
      longint su, sv;
      point_type pt;
      if (hw < 32 || hh < 32 || d == 0) return;
      su = longint'(u) * 16;
      sv = longint'(v) * 16;
      du = (su > cu) ? su - cu : cu - su;
      dv = (sv > cv) ? sv - cv : cv - sv;
      if (du > hw || dv > hh) return;
      hw2 = hw * hw; hh2 = hh * hh;
      a = du * du * hh2; b = dv * dv * hw2; p = hw2 * hh2;
      if (b > p || a > p - b) return;
      s = a + b;
      r2 = 128 * 128;
      lim = r2 * (p >> 16) + ((r2 * (p & 64'hFFFF)) >> 16);
      if (s <= lim) return;
      pt.clip = 0;
      pt.x = axis((su - pu0) * longint'(d), fx, pt.clip);
      pt.y = axis((sv - pv0) * longint'(d), fy, pt.clip);
      pt.z = d;
      pending = {pending, pt};
   endfunction

   function void report(string what);
      $display("mismatch: %s", what);
      errors++;
   endfunction

   function void check_point(logic [63:0] data, logic clip);
      point_type e;
      if (pending.size() == 0) begin
         report($sformatf("unexpected point %h", data));
         return;
      end
      e = pending.pop_front();
      if (data[20:0] != e.x) report($sformatf("x %h exp %h", data[20:0], e.x));
      if (data[41:21] != e.y) report($sformatf("y %h exp %h", data[41:21], e.y));
      if (data[57:42] != e.z) report($sformatf("z %h exp %h", data[57:42], e.z));
      if (data[63:58] != 0) report("pad bits not zero");
      if (clip !== e.clip) report($sformatf("clipped %b exp %b", clip, e.clip));
   endfunction
endclass

module tb_depth_annulus_point_extract_core;
   import dape_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tready;
   logic [39:0] req_tdata = 0;
   logic        rsp_tvalid, rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 0, csr_ready;
   logic [3:0]  csr_index = 0;
   logic [15:0] csr_data = 0;

   point_scoreboard board = new();
   int  idle_cycles = 0;
   int  burst_left = 0;
   localparam int WATCHDOG = 5000;

   depth_annulus_point_extract_core DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver stall pattern
   int stall_mode = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 3) != 0;
         2: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= $urandom_range(0, 7) == 0;
      endcase
   end

   // check points and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_point(rsp_tdata, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // leaves csr_valid high; set_box drops it after the last write
   task automatic write_csr(reg_index_type idx, logic [15:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
   endtask

   // send one pixel; bursts with random gaps
   task automatic send_pixel(logic [11:0] u, logic [11:0] v, logic [15:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= {d, v, u};
      do @(posedge clock); while (!req_tready);
      board.note_pixel(u, v, d);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DIV_LAT + 10) @(negedge clock);
   endtask

   task automatic set_box(logic [15:0] cu, cv, hw, hh, fx, fy, pu, pv);
      write_csr(REG_CENTER_U, cu);
      write_csr(REG_CENTER_V, cv);
      write_csr(REG_HALF_WIDTH, hw);
      write_csr(REG_HALF_HEIGHT, hh);
      write_csr(REG_FOCAL_X, fx);
      write_csr(REG_FOCAL_Y, fy);
      write_csr(REG_PRINCIPAL_U, pu);
      write_csr(REG_PRINCIPAL_V, pv);
      csr_valid <= 0;
   endtask

   // pixel mostly near the box, sometimes anywhere, random depth
   task automatic random_pixel();
      int du, dv;
      logic [15:0] d;
      int su, sv;
      du = (board.hw / 16) + 2;
      dv = (board.hh / 16) + 2;
      case ($urandom_range(0, 9))
         0: d = 0;
         1: d = 16'hFFFF;
         default: d = 16'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) begin
         su = $urandom_range(0, 4095);
         sv = $urandom_range(0, 4095);
      end else begin
         su = board.cu / 16 + $urandom_range(0, 2 * du) - du;
         sv = board.cv / 16 + $urandom_range(0, 2 * dv) - dv;
         if (su < 0) su = 0; if (su > 4095) su = 4095;
         if (sv < 0) sv = 0; if (sv > 4095) sv = 4095;
      end
      send_pixel(12'(su), 12'(sv), d);
   endtask

   initial begin
      board.reset_regs();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // reset config: box too small, nothing comes out
      send_pixel(0, 0, 100);
      send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
      drain();

      // directed: centred box with extremes
      set_box(16'd8000, 16'd8000, 16'd800, 16'd480, 16'd9600, 16'd9600, 16'd5000, 16'd5000);
      send_pixel(500, 500, 1000);          // centre, inside inner ellipse
      send_pixel(550, 500, 1000);          // on outer edge
      send_pixel(551, 500, 1000);          // just outside
      send_pixel(540, 500, 0);             // invalid depth
      send_pixel(540, 500, 16'hFFFF);
      send_pixel(460, 500, 16'hFFFF);
      send_pixel(500, 530, 1);
      send_pixel(500, 470, 16'h8000);
      send_pixel(525, 500, 500);           // on inner edge
      drain();
      // zero focal length and clipping
      set_box(16'd65520, 16'd65520, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0);
      send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
      send_pixel(12'hFFF, 0, 16'hFFFF);
      send_pixel(0, 12'hFFF, 16'hFFFF);
      send_pixel(0, 0, 16'hFFFF);
      drain();
      // minimum box sizes around the 2 px limit
      set_box(16'd1600, 16'd1600, 16'd31, 16'd64, 16'd1, 16'd65535, 16'd65535, 16'd0);
      send_pixel(101, 100, 1000);
      drain();
      set_box(16'd1600, 16'd1600, 16'd32, 16'd32, 16'd1, 16'd65535, 16'd65535, 16'd65535);
      send_pixel(102, 100, 1000);
      send_pixel(100, 102, 1000);
      send_pixel(100, 100, 1000);
      drain();

      // random phases with fresh settings
      for (int ph = 0; ph < 10; ph++) begin
         set_box(16'($urandom), 16'($urandom),
                 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(20, 3000)),
                 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(20, 3000)),
                 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 50)),
                 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 50)),
                 16'($urandom), 16'($urandom));
         repeat (85) random_pixel();
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

`default_nettype wire
